// ===== src/scfr_pkg.sv =====
// Shared types and constants for the serial command frame receiver.
`default_nettype none
package scfr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 9;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'h57;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'hAB;

	localparam logic REG_FIRST_SYNC  = 1'b0;
	localparam logic REG_SECOND_SYNC = 1'b1;

	localparam logic [POS_W-1:0] POS_HDR0    = 9'd0;
	localparam logic [POS_W-1:0] POS_HDR1    = 9'd1;
	localparam logic [POS_W-1:0] POS_HDR2    = 9'd2;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd3;

	typedef enum logic [2:0] {
		PH_HUNT1   = 3'd0,
		PH_HUNT2   = 3'd1,
		PH_HDR0    = 3'd2,
		PH_HDR1    = 3'd3,
		PH_HDR2    = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CHECK   = 3'd6
	} phase_t;

	typedef struct packed {
		logic              has;
		logic [BYTE_W-1:0] out_byte;
		logic [POS_W-1:0]  byte_position;
		logic              frame_end;
		logic              frame_good;
	} res_t;

endpackage
`default_nettype wire

// ===== src/serial_command_frame_receiver.sv =====
// Serial command frame receiver top level: input register, parser, result register, APB registers.
// Path: a byte accepted into the input register is parsed from there, and its result is
// captured in the result register when that register is empty or being taken.
// Throughput: one byte per cycle while the output is not stalled; the input register advances
// whenever the result register is empty or being taken, so a stalled output holds the waiting
// result plus one byte in the input register.
// Reset: arst_n clears the phase to preamble hunt, the length, count and sum to zero,
// both valid flags, and loads the sync registers with 0x57 and 0xAB.
`default_nettype none
module serial_command_frame_receiver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rx_valid,
	output logic                               rx_stall,
	input  wire logic [scfr_pkg::BYTE_W-1:0]   rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [scfr_pkg::BYTE_W-1:0]        out_byte,
	output logic [scfr_pkg::POS_W-1:0]         byte_position,
	output logic                               frame_end,
	output logic                               frame_good,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scfr_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [scfr_pkg::DATA_W-1:0]   pwdata,
	output logic [scfr_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	logic [scfr_pkg::BYTE_W-1:0] first_sync_q;
	logic [scfr_pkg::BYTE_W-1:0] second_sync_q;
	logic                        valid_s1;
	logic [scfr_pkg::BYTE_W-1:0] byte_s1;
	logic                        fire;
	logic                        wr_en;
	scfr_pkg::res_t              res;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= scfr_pkg::FIRST_SYNC_RESET;
			second_sync_q <= scfr_pkg::SECOND_SYNC_RESET;
		end else if (wr_en) begin
			if (paddr[2] == scfr_pkg::REG_FIRST_SYNC) begin
				first_sync_q <= pwdata[scfr_pkg::BYTE_W-1:0];
			end else begin
				second_sync_q <= pwdata[scfr_pkg::BYTE_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == scfr_pkg::REG_SECOND_SYNC) begin
			prdata = {{(scfr_pkg::DATA_W-scfr_pkg::BYTE_W){1'b0}}, second_sync_q};
		end else begin
			prdata = {{(scfr_pkg::DATA_W-scfr_pkg::BYTE_W){1'b0}}, first_sync_q};
		end
	end

	// advance the input register when the result register can take its transaction
	assign fire     = valid_s1 && (!out_valid || !out_stall);
	assign rx_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	scfr_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.rx_byte     (byte_s1),
		.first_sync  (first_sync_q),
		.second_sync (second_sync_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= res.has;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has) begin
			out_byte      <= res.out_byte;
			byte_position <= res.byte_position;
			frame_end     <= res.frame_end;
			frame_good    <= res.frame_good;
		end
	end

endmodule
`default_nettype wire

// ===== src/scfr_parse.sv =====
// Frame parser: phase state machine, length and count tracking, running sum.
`default_nettype none
module scfr_parse (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [scfr_pkg::BYTE_W-1:0]   rx_byte,
	input  wire logic [scfr_pkg::BYTE_W-1:0]   first_sync,
	input  wire logic [scfr_pkg::BYTE_W-1:0]   second_sync,
	output scfr_pkg::res_t                     res
);

	scfr_pkg::phase_t             phase_q, phase_d;
	logic [scfr_pkg::BYTE_W-1:0]  length_q, length_d;
	logic [scfr_pkg::BYTE_W-1:0]  count_q, count_d;
	logic [scfr_pkg::BYTE_W-1:0]  sum_q, sum_d;
	logic [scfr_pkg::BYTE_W-1:0]  count_inc;
	logic [scfr_pkg::BYTE_W-1:0]  sum_add;

	assign count_inc = count_q + 8'd1;
	assign sum_add   = sum_q + rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scfr_pkg::PH_HUNT1;
			length_q <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
		end
	end

	always_comb begin
		phase_d            = phase_q;
		length_d           = length_q;
		count_d            = count_q;
		sum_d              = sum_q;
		res.has            = 1'b0;
		res.out_byte       = rx_byte;
		res.byte_position  = scfr_pkg::POS_HDR0;
		res.frame_end      = 1'b0;
		res.frame_good     = 1'b0;
		unique case (phase_q)
			scfr_pkg::PH_HUNT2: begin
				phase_d = (rx_byte == second_sync) ? scfr_pkg::PH_HDR0 : scfr_pkg::PH_HUNT1;
				sum_d   = '0;
				count_d = '0;
			end
			scfr_pkg::PH_HDR0: begin
				sum_d   = sum_add;
				phase_d = scfr_pkg::PH_HDR1;
				res.has = 1'b1;
			end
			scfr_pkg::PH_HDR1: begin
				sum_d             = sum_add;
				length_d          = rx_byte;
				phase_d           = scfr_pkg::PH_HDR2;
				res.has           = 1'b1;
				res.byte_position = scfr_pkg::POS_HDR1;
			end
			scfr_pkg::PH_HDR2: begin
				sum_d             = sum_add;
				count_d           = '0;
				phase_d           = (length_q == '0) ? scfr_pkg::PH_CHECK : scfr_pkg::PH_PAYLOAD;
				res.has           = 1'b1;
				res.byte_position = scfr_pkg::POS_HDR2;
			end
			scfr_pkg::PH_PAYLOAD: begin
				sum_d             = sum_add;
				count_d           = count_inc;
				if (count_inc == length_q) begin
					phase_d = scfr_pkg::PH_CHECK;
				end
				res.has           = 1'b1;
				res.byte_position = scfr_pkg::POS_PAYLOAD + {1'b0, count_q};
			end
			scfr_pkg::PH_CHECK: begin
				phase_d           = scfr_pkg::PH_HUNT1;
				res.has           = 1'b1;
				res.byte_position = scfr_pkg::POS_PAYLOAD + {1'b0, length_q};
				res.frame_end     = 1'b1;
				res.frame_good    = (rx_byte == sum_q);
			end
			default: begin
				phase_d = (rx_byte == first_sync) ? scfr_pkg::PH_HUNT2 : scfr_pkg::PH_HUNT1;
			end
		endcase
	end

endmodule
`default_nettype wire
